FILE: rtl/core/phong_pkg.sv
// ----------------------------------------------------------------------------
// Phong shading package
// Shared types and constants: 16-bit unit fraction, register indexes.
// ----------------------------------------------------------------------------
package phong_pkg;

	// unit fraction, all ones means 1.0
	localparam int UNIT_BITS = 16;
	typedef logic [UNIT_BITS-1:0] unit_t;
	localparam unit_t UNIT_MAX = '1;

	// configuration register indexes
	localparam int REG_IDX_BITS = 2;
	typedef logic [REG_IDX_BITS-1:0] reg_idx_t;
	localparam reg_idx_t REG_DIFFUSE_COLOR  = 2'd0;
	localparam reg_idx_t REG_SPECULAR_COLOR = 2'd1;
	localparam reg_idx_t REG_SHININESS      = 2'd2;

endpackage

FILE: rtl/core/phong_if.sv
// ----------------------------------------------------------------------------
// Phong shading channels
// Sample input, shaded result and configuration write channels.
// ----------------------------------------------------------------------------
interface phong_in_if #(
	parameter int COMPONENT_BITS = 16,
	parameter int COLOR_BITS     = 8
);
	logic                        valid;
	logic                        ready;
	logic [3*COMPONENT_BITS-1:0] incoming_dir;
	logic [3*COMPONENT_BITS-1:0] normal_dir;
	logic [3*COMPONENT_BITS-1:0] reflect_dir;
	logic [3*COMPONENT_BITS-1:0] view_dir;
	logic [3*COLOR_BITS-1:0]     light_color;

	modport source (output valid, incoming_dir, normal_dir, reflect_dir, view_dir,
		light_color, input ready);
	modport sink (input valid, incoming_dir, normal_dir, reflect_dir, view_dir,
		light_color, output ready);
endinterface

interface phong_out_if;
	logic               valid;
	logic               ready;
	phong_pkg::unit_t   diffuse_red;
	phong_pkg::unit_t   diffuse_green;
	phong_pkg::unit_t   diffuse_blue;
	phong_pkg::unit_t   specular_red;
	phong_pkg::unit_t   specular_green;
	phong_pkg::unit_t   specular_blue;

	modport source (output valid, diffuse_red, diffuse_green, diffuse_blue,
		specular_red, specular_green, specular_blue, input ready);
	modport sink (input valid, diffuse_red, diffuse_green, diffuse_blue,
		specular_red, specular_green, specular_blue, output ready);
endinterface

interface phong_cfg_if #(
	parameter int COLOR_BITS = 8
);
	logic                    valid;
	logic                    ready;
	phong_pkg::reg_idx_t     index;
	logic [3*COLOR_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/phong_light_shading_core.sv
// ----------------------------------------------------------------------------
// Phong light shading core
// Per-light diffuse and specular intensities of one surface sample.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one word per sample: incoming, normal, reflect and view vectors
//          (three signed components each) plus the packed RGB light color.
//   rsp  : one word per sample: diffuse and specular RGB, 16-bit fractions.
//   cfg  : register writes (diffuse color, specular color, shininess); always
//          ready, write only while no sample is in flight.
// Stages in order: dot products, clamp, unit conversion, one stage per
// exponent bit of the square-and-multiply power, one color product stage,
// then eight stages of the divide by the color full-scale squared at two
// quotient bits each.
// Throughput is one word per cycle. Every stage has its own valid bit and
// loads whenever it is empty or its word moves on, so bubbles collapse and
// req stays ready while rsp is stalled until the pipeline is full.
// Reset clears all valid bits and loads the register defaults (diffuse pure
// red, specular black, shininess 2); no clearing pass is needed.
// ----------------------------------------------------------------------------
module phong_light_shading_core #(
	parameter int COMPONENT_BITS = 16,
	parameter int COLOR_BITS     = 8,
	parameter int EXPONENT_BITS  = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	phong_in_if.sink      req,
	phong_out_if.source   rsp,
	phong_cfg_if.sink     cfg
);

	localparam int UB   = phong_pkg::UNIT_BITS;
	localparam int CB   = COMPONENT_BITS;
	localparam int FB   = CB - 2;
	localparam int PW   = 2 * CB;
	localparam int SW   = PW + 2;
	localparam int DW   = 2 * FB + 1;
	localparam int UCW  = 2 * FB + UB + 1;
	localparam int CLB  = COLOR_BITS;
	localparam int LMW  = 2 * CLB;
	localparam int XW   = LMW + UB;
	localparam int EB   = EXPONENT_BITS;
	localparam int QST  = UB / 2;
	localparam int ST_POW0 = 3;
	localparam int ST_PROD = ST_POW0 + EB;
	localparam int ST_DIV0 = ST_PROD + 1;
	localparam int NS      = ST_DIV0 + QST;

	localparam longint unsigned CMAX_L = (64'd1 << CLB) - 64'd1;
	localparam longint unsigned DEN_L  = CMAX_L * CMAX_L;
	localparam logic [LMW-1:0] DEN      = LMW'(DEN_L);
	localparam logic [LMW-1:0] DEN_HALF = LMW'(DEN_L / 2);

	localparam logic [DW-1:0]  DOT_ONE    = {1'b1, {(DW-1){1'b0}}};
	localparam logic [SW-1:0]  DOT_ONE_SW = SW'(DOT_ONE);
	localparam logic [UCW-1:0] UNIT_HALF  = UCW'(1) << (2 * FB - 1);

	typedef phong_pkg::unit_t unit_t;

	// ---------------- helpers ----------------
	function automatic logic signed [CB-1:0] comp(input logic [3*CB-1:0] v, input int i);
		return v[(2-i)*CB +: CB];
	endfunction

	function automatic logic [CLB-1:0] chan(input logic [3*CLB-1:0] v, input int i);
		return v[(2-i)*CLB +: CLB];
	endfunction

	function automatic logic [DW-1:0] clamp_dot(input logic signed [SW-1:0] s);
		logic [DW-1:0] r;
		if (s[SW-1])
			r = '0;
		else if (s > DOT_ONE_SW)
			r = DOT_ONE;
		else
			r = s[DW-1:0];
		return r;
	endfunction

	// d * 65535 rounded to nearest on the unit scale
	function automatic unit_t unit_conv(input logic [DW-1:0] d);
		logic [UCW-1:0] t;
		t = {d, {UB{1'b0}}} - UCW'(d) + UNIT_HALF;
		return t[2*FB+UB-1 -: UB];
	endfunction

	// (a*b + 32767) / 65535; the quotient fits 16 bits, so one fold is exact
	function automatic unit_t frac_mul(input unit_t a, input unit_t b);
		logic [2*UB-1:0] p;
		logic [2*UB:0]   t;
		p = (2*UB)'(a) * (2*UB)'(b) + (2*UB)'(phong_pkg::UNIT_MAX >> 1);
		t = {1'b0, p} + (2*UB+1)'(p[2*UB-1:UB]) + (2*UB+1)'(1);
		return t[2*UB-1:UB];
	endfunction

	// two restoring divide steps, quotient bits shift in at the bottom
	function automatic logic [LMW+UB-1:0] div2(input logic [LMW-1:0] rem, input unit_t ql);
		logic [LMW:0]   t;
		logic [LMW-1:0] r;
		unit_t          q;
		r = rem;
		q = ql;
		for (int s = 0; s < 2; s++) begin
			t = {r, q[UB-1]};
			if (t >= {1'b0, DEN}) begin
				t = t - {1'b0, DEN};
				q = {q[UB-2:0], 1'b1};
			end else begin
				q = {q[UB-2:0], 1'b0};
			end
			r = t[LMW-1:0];
		end
		return {r, q};
	endfunction

	// ---------------- configuration ----------------
	logic [3*CLB-1:0] diffuse_q;
	logic [3*CLB-1:0] specular_q;
	logic [EB-1:0]    shininess_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diffuse_q   <= {CLB'(CMAX_L), {(2*CLB){1'b0}}};
			specular_q  <= '0;
			shininess_q <= EB'(2);
		end else if (cfg.valid) begin
			case (cfg.index)
				phong_pkg::REG_DIFFUSE_COLOR:  diffuse_q   <= cfg.data;
				phong_pkg::REG_SPECULAR_COLOR: specular_q  <= cfg.data;
				phong_pkg::REG_SHININESS:      shininess_q <= cfg.data[EB-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- valid / enable chain ----------------
	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;
	logic [NS-1:0] vin;

	assign vin[0]    = req.valid;
	assign en[NS-1]  = !vld_q[NS-1] || rsp.ready;
	assign req.ready = en[0];

	for (genvar k = 1; k < NS; k++) begin : g_vin
		assign vin[k] = vld_q[k-1];
	end

	for (genvar k = 0; k < NS - 1; k++) begin : g_en
		assign en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (en[k])
					vld_q[k] <= vin[k];
			end
		end
	end

	// ---------------- s1: component and color products ----------------
	logic signed [PW-1:0] prod_d_s1 [3];
	logic signed [PW-1:0] prod_s_s1 [3];
	logic [LMW-1:0]       lm_s1 [6];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				prod_d_s1[i] <= comp(req.incoming_dir, i) * comp(req.normal_dir, i);
				prod_s_s1[i] <= comp(req.reflect_dir, i) * comp(req.view_dir, i);
				lm_s1[i]     <= LMW'(chan(req.light_color, i)) * LMW'(chan(diffuse_q, i));
				lm_s1[i+3]   <= LMW'(chan(req.light_color, i)) * LMW'(chan(specular_q, i));
			end
		end
	end

	// ---------------- s2: dot sums, clamp to 0..1 ----------------
	logic [DW-1:0]  dot_d_s2;
	logic [DW-1:0]  dot_s_s2;
	logic [LMW-1:0] lm_s2 [6];
	logic signed [SW-1:0] sum_d;
	logic signed [SW-1:0] sum_s;

	always_comb begin
		sum_d = SW'(prod_d_s1[0]) + SW'(prod_d_s1[1]) + SW'(prod_d_s1[2]);
		sum_s = SW'(prod_s_s1[0]) + SW'(prod_s_s1[1]) + SW'(prod_s_s1[2]);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			dot_d_s2 <= clamp_dot(sum_d);
			dot_s_s2 <= clamp_dot(sum_s);
			lm_s2    <= lm_s1;
		end
	end

	// ---------------- s3: convert to 16-bit fraction ----------------
	unit_t          d16_s3;
	unit_t          s16_s3;
	logic [LMW-1:0] lm_s3 [6];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			d16_s3 <= unit_conv(dot_d_s2);
			s16_s3 <= unit_conv(dot_s_s2);
			lm_s3  <= lm_s2;
		end
	end

	// ---------------- s4: square-and-multiply, one exponent bit per stage ----
	unit_t          res_s4  [EB];
	unit_t          base_s4 [EB];
	unit_t          d16_s4  [EB];
	logic [LMW-1:0] lm_s4   [EB][6];

	for (genvar k = 0; k < EB; k++) begin : g_pow
		unit_t          res_in;
		unit_t          base_in;
		unit_t          d16_in;
		logic [LMW-1:0] lm_in [6];

		if (k == 0) begin : g_first
			assign res_in  = phong_pkg::UNIT_MAX;
			assign base_in = s16_s3;
			assign d16_in  = d16_s3;
			assign lm_in   = lm_s3;
		end else begin : g_next
			assign res_in  = res_s4[k-1];
			assign base_in = base_s4[k-1];
			assign d16_in  = d16_s4[k-1];
			assign lm_in   = lm_s4[k-1];
		end

		always_ff @(posedge clk) begin
			if (en[ST_POW0+k]) begin
				res_s4[k]  <= shininess_q[k] ? frac_mul(res_in, base_in) : res_in;
				base_s4[k] <= frac_mul(base_in, base_in);
				d16_s4[k]  <= d16_in;
				lm_s4[k]   <= lm_in;
			end
		end
	end

	// ---------------- s5: light * material * factor ----------------
	logic [XW-1:0] x_s5 [6];

	always_ff @(posedge clk) begin
		if (en[ST_PROD]) begin
			for (int c = 0; c < 3; c++) begin
				x_s5[c]   <= XW'(lm_s4[EB-1][c]) * XW'(d16_s4[EB-1]) + XW'(DEN_HALF);
				x_s5[c+3] <= XW'(lm_s4[EB-1][c+3]) * XW'(res_s4[EB-1]) + XW'(DEN_HALF);
			end
		end
	end

	// ---------------- s6: divide by full-scale squared ----------------
	// x < DEN * 2^16, so the top part starts below DEN and the quotient
	// never exceeds 65535 (saturation cannot trigger)
	logic [LMW-1:0] rem_s6 [QST][6];
	unit_t          qlo_s6 [QST][6];

	for (genvar j = 0; j < QST; j++) begin : g_div
		logic [LMW-1:0] rem_in [6];
		unit_t          qlo_in [6];

		for (genvar c = 0; c < 6; c++) begin : g_ch
			if (j == 0) begin : g_first
				assign rem_in[c] = x_s5[c][XW-1:UB];
				assign qlo_in[c] = x_s5[c][UB-1:0];
			end else begin : g_next
				assign rem_in[c] = rem_s6[j-1][c];
				assign qlo_in[c] = qlo_s6[j-1][c];
			end
		end

		always_ff @(posedge clk) begin
			if (en[ST_DIV0+j]) begin
				for (int c = 0; c < 6; c++)
					{rem_s6[j][c], qlo_s6[j][c]} <= div2(rem_in[c], qlo_in[c]);
			end
		end
	end

	assign rsp.valid          = vld_q[NS-1];
	assign rsp.diffuse_red    = qlo_s6[QST-1][0];
	assign rsp.diffuse_green  = qlo_s6[QST-1][1];
	assign rsp.diffuse_blue   = qlo_s6[QST-1][2];
	assign rsp.specular_red   = qlo_s6[QST-1][3];
	assign rsp.specular_green = qlo_s6[QST-1][4];
	assign rsp.specular_blue  = qlo_s6[QST-1][5];

	// ---------------- assertions ----------------
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q) && !rsp.ready |-> !req.ready)
		else $error("input accepted while pipeline full and output stalled");

	a_clamp_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[2] |-> (dot_d_s2 <= DOT_ONE) && (dot_s_s2 <= DOT_ONE))
		else $error("clamped dot product above one");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NS-1] |-> (rem_s6[QST-1][0] < DEN) && (rem_s6[QST-1][5] < DEN))
		else $error("divide remainder not below divisor");

endmodule

FILE: tb/phong_light_shading_core_tb.sv
// ----------------------------------------------------------------------------
// Phong light shading core testbench
// Sends surface samples through the core under several material settings and
// checks every shaded word against an in-bench fixed-point predictor: clamped
// dot products, square-and-multiply specular power, rounded color products.
// ----------------------------------------------------------------------------
module phong_light_shading_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COMPONENT_BITS = 16;
	localparam int COLOR_BITS     = 8;
	localparam int EXPONENT_BITS  = 8;
	localparam int FRAC_BITS      = COMPONENT_BITS - 2;
	localparam int Q_ONE          = 1 << FRAC_BITS;
	localparam int PIPE_LATENCY   = EXPONENT_BITS + 12;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_SAMPLES  = 125;
	localparam longint unsigned CMAX      = (64'd1 << COLOR_BITS) - 1;
	localparam longint unsigned UNIT_FULL = 64'(phong_pkg::UNIT_MAX);
	// index with no register behind it
	localparam phong_pkg::reg_idx_t REG_UNMAPPED = 2'd3;

	typedef logic [3*COMPONENT_BITS-1:0] vec_t;
	typedef logic [3*COLOR_BITS-1:0]     rgb_t;
	typedef logic [EXPONENT_BITS-1:0]    exp_t;

	typedef struct packed {
		vec_t incoming;
		vec_t normal;
		vec_t reflect;
		vec_t view;
		rgb_t light;
	} sample_t;

	typedef struct packed {
		phong_pkg::unit_t diffuse_red;
		phong_pkg::unit_t diffuse_green;
		phong_pkg::unit_t diffuse_blue;
		phong_pkg::unit_t specular_red;
		phong_pkg::unit_t specular_green;
		phong_pkg::unit_t specular_blue;
	} shade_t;

	typedef enum {STALL_NONE, STALL_COIN, STALL_SCARCE, STALL_BEAT} stall_mode_t;

	logic clk;
	logic arst_n;

	phong_in_if #(.COMPONENT_BITS(COMPONENT_BITS), .COLOR_BITS(COLOR_BITS)) req ();
	phong_out_if rsp ();
	phong_cfg_if #(.COLOR_BITS(COLOR_BITS)) cfg ();

	phong_light_shading_core #(
		.COMPONENT_BITS(COMPONENT_BITS),
		.COLOR_BITS(COLOR_BITS),
		.EXPONENT_BITS(EXPONENT_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	// material registers as the core should hold them
	rgb_t diffuse_reg;
	rgb_t specular_reg;
	exp_t shine_reg;

	shade_t expected_shades[$];
	int     error_count = 0;
	int     cycle_count = 0;
	int     burst_left  = 0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------- predictor ----------------

	function automatic longint signed vec_comp(vec_t v, int i);
		logic signed [COMPONENT_BITS-1:0] c;
		c = v[(2-i)*COMPONENT_BITS +: COMPONENT_BITS];
		return longint'(c);
	endfunction

	// dot product clamped to 0..1 and rescaled to a 16-bit fraction
	function automatic longint unsigned unit_dot(vec_t a, vec_t b);
		longint signed acc;
		longint signed full;
		int i;
		full = longint'(1) << (2*FRAC_BITS);
		acc = 0;
		for (i = 0; i < 3; i++)
			acc += vec_comp(a, i) * vec_comp(b, i);
		if (acc < 0)
			acc = 0;
		if (acc > full)
			acc = full;
		return (acc * longint'(UNIT_FULL) + (longint'(1) << (2*FRAC_BITS-1))) >> (2*FRAC_BITS);
	endfunction

	function automatic longint unsigned unit_mul(longint unsigned a, longint unsigned b);
		return (a * b + UNIT_FULL/2) / UNIT_FULL;
	endfunction

	function automatic longint unsigned unit_pow(longint unsigned base, exp_t e);
		longint unsigned r;
		int i;
		r = UNIT_FULL;
		for (i = 0; i < EXPONENT_BITS; i++) begin
			if (e[i])
				r = unit_mul(r, base);
			base = unit_mul(base, base);
		end
		return r;
	endfunction

	function automatic longint unsigned rgb_chan(rgb_t c, int i);
		return 64'(c[(2-i)*COLOR_BITS +: COLOR_BITS]);
	endfunction

	function automatic phong_pkg::unit_t tint(longint unsigned l, longint unsigned m,
			longint unsigned f);
		longint unsigned v;
		v = (l * m * f + (CMAX*CMAX)/2) / (CMAX*CMAX);
		return (v > UNIT_FULL) ? phong_pkg::UNIT_MAX : phong_pkg::unit_t'(v);
	endfunction

	function automatic shade_t predict_shade(sample_t s);
		shade_t r;
		longint unsigned d16;
		longint unsigned p16;
		d16 = unit_dot(s.incoming, s.normal);
		p16 = unit_pow(unit_dot(s.reflect, s.view), shine_reg);
		r.diffuse_red    = tint(rgb_chan(s.light, 0), rgb_chan(diffuse_reg, 0), d16);
		r.diffuse_green  = tint(rgb_chan(s.light, 1), rgb_chan(diffuse_reg, 1), d16);
		r.diffuse_blue   = tint(rgb_chan(s.light, 2), rgb_chan(diffuse_reg, 2), d16);
		r.specular_red   = tint(rgb_chan(s.light, 0), rgb_chan(specular_reg, 0), p16);
		r.specular_green = tint(rgb_chan(s.light, 1), rgb_chan(specular_reg, 1), p16);
		r.specular_blue  = tint(rgb_chan(s.light, 2), rgb_chan(specular_reg, 2), p16);
		return r;
	endfunction

	// ---------------- checking ----------------

	function automatic void log_error(string msg);
		error_count++;
		if (error_count <= 10)
			$display("%s", msg);
	endfunction

	function automatic void check_field(string name, phong_pkg::unit_t want,
			phong_pkg::unit_t got);
		if (got !== want)
			log_error($sformatf("%0d: %s expected %0d got %0d", cycle_count, name, want, got));
	endfunction

	always @(posedge clk) begin
		shade_t want;
		if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (expected_shades.size() == 0) begin
				log_error($sformatf("%0d: shaded word with none outstanding", cycle_count));
			end else begin
				want = expected_shades.pop_front();
				check_field("diffuse_red", want.diffuse_red, rsp.diffuse_red);
				check_field("diffuse_green", want.diffuse_green, rsp.diffuse_green);
				check_field("diffuse_blue", want.diffuse_blue, rsp.diffuse_blue);
				check_field("specular_red", want.specular_red, rsp.specular_red);
				check_field("specular_green", want.specular_green, rsp.specular_green);
				check_field("specular_blue", want.specular_blue, rsp.specular_blue);
			end
		end
	end

	// receiver back-pressure, switching pattern every so often
	initial begin
		stall_mode_t mode;
		int left;
		rsp.ready = 1'b0;
		mode = STALL_NONE;
		left = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = stall_mode_t'($urandom_range(0, 3));
				left = $urandom_range(16, 160);
			end
			left--;
			case (mode)
				STALL_NONE:   rsp.ready <= 1'b1;
				STALL_COIN:   rsp.ready <= ($urandom_range(0, 1) == 1);
				STALL_SCARCE: rsp.ready <= ($urandom_range(0, 3) == 0);
				default:      rsp.ready <= left[2];
			endcase
		end
	end

	// ---------------- stimulus helpers ----------------

	function automatic vec_t pack_vec(int x, int y, int z);
		return {COMPONENT_BITS'(x), COMPONENT_BITS'(y), COMPONENT_BITS'(z)};
	endfunction

	function automatic sample_t make_sample(vec_t in_d, vec_t nrm, vec_t refl, vec_t vw,
			rgb_t light);
		sample_t s;
		s.incoming = in_d;
		s.normal   = nrm;
		s.reflect  = refl;
		s.view     = vw;
		s.light    = light;
		return s;
	endfunction

	function automatic vec_t rand_bits();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[3*COMPONENT_BITS-1:0];
	endfunction

	// unit vector along one axis, every component jittered by up to spread
	function automatic vec_t near_axis(int axis, bit neg, int spread);
		int c[3];
		int i;
		for (i = 0; i < 3; i++)
			c[i] = int'($urandom_range(0, 2*spread)) - spread;
		c[axis] += neg ? -Q_ONE : Q_ONE;
		return pack_vec(c[0], c[1], c[2]);
	endfunction

	function automatic vec_t rand_unit_box();
		return pack_vec(int'($urandom_range(0, 2*Q_ONE)) - Q_ONE,
			int'($urandom_range(0, 2*Q_ONE)) - Q_ONE,
			int'($urandom_range(0, 2*Q_ONE)) - Q_ONE);
	endfunction

	function automatic sample_t rand_sample();
		sample_t s;
		int kind;
		int axis;
		bit neg;
		int spread;
		kind = $urandom_range(0, 9);
		s.light = ($urandom_range(0, 5) == 0) ? '1 : rgb_t'($urandom);
		if (kind < 2) begin
			s.incoming = rand_bits();
			s.normal   = rand_bits();
			s.reflect  = rand_bits();
			s.view     = rand_bits();
		end else if (kind < 8) begin
			// near-aligned pairs keep the dots close to one so high powers stay nonzero
			axis = $urandom_range(0, 2);
			neg = ($urandom_range(0, 1) == 1);
			spread = $urandom_range(0, 2048);
			s.incoming = near_axis(axis, neg, spread);
			s.normal = near_axis(axis, ($urandom_range(0, 4) == 0) ? !neg : neg, spread);
			axis = $urandom_range(0, 2);
			neg = ($urandom_range(0, 1) == 1);
			spread = $urandom_range(0, 512);
			s.reflect = near_axis(axis, neg, spread);
			s.view = near_axis(axis, ($urandom_range(0, 4) == 0) ? !neg : neg, spread);
		end else begin
			s.incoming = rand_unit_box();
			s.normal   = rand_unit_box();
			s.reflect  = rand_unit_box();
			s.view     = rand_unit_box();
		end
		return s;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance, or later when an idle gap follows
	task automatic send_sample(sample_t s);
		req.valid        <= 1'b1;
		req.incoming_dir <= s.incoming;
		req.normal_dir   <= s.normal;
		req.reflect_dir  <= s.reflect;
		req.view_dir     <= s.view;
		req.light_color  <= s.light;
		@(posedge clk);
		while (req.ready !== 1'b1)
			@(posedge clk);
		expected_shades.push_back(predict_shade(s));
		@(negedge clk);
		// sender bursts: valid only drops when a gap follows
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
				: $urandom_range(0, 15);
		end
	endtask

	task automatic write_reg(phong_pkg::reg_idx_t idx, rgb_t value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		@(posedge clk);
		while (cfg.ready !== 1'b1)
			@(posedge clk);
		case (idx)
			phong_pkg::REG_DIFFUSE_COLOR:  diffuse_reg = value;
			phong_pkg::REG_SPECULAR_COLOR: specular_reg = value;
			phong_pkg::REG_SHININESS:      shine_reg = value[EXPONENT_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	// wait for every outstanding word, then let the pipe empty
	task automatic settle();
		req.valid <= 1'b0;
		while (expected_shades.size() != 0)
			@(negedge clk);
		repeat (PIPE_LATENCY + 4) @(negedge clk);
	endtask

	// ---------------- tests ----------------

	task automatic test_reset_config();
		send_sample(make_sample('0, '0, '0, '0, '1));
		send_sample(make_sample('1, '1, '1, '1, '1));
		send_sample(make_sample(pack_vec(Q_ONE, 0, 0), pack_vec(Q_ONE, 0, 0),
			pack_vec(0, Q_ONE, 0), pack_vec(0, Q_ONE, 0), '1));
		send_sample(make_sample(pack_vec(Q_ONE, 0, 0), pack_vec(Q_ONE/2, 0, 0),
			pack_vec(0, 0, Q_ONE), pack_vec(0, 0, Q_ONE), 24'h80FF40));
	endtask

	task automatic test_edge_cases();
		settle();
		write_reg(phong_pkg::REG_DIFFUSE_COLOR, '1);
		write_reg(phong_pkg::REG_SPECULAR_COLOR, '1);
		write_reg(phong_pkg::REG_SHININESS, 24'd2);
		// negative dots clamp to zero
		send_sample(make_sample(pack_vec(Q_ONE, 0, 0), pack_vec(-Q_ONE, 0, 0),
			pack_vec(0, Q_ONE, 0), pack_vec(0, -Q_ONE, 0), '1));
		// largest magnitudes: dots above one clamp to one, mixed signs clamp to zero
		send_sample(make_sample({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, '1));
		send_sample(make_sample({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, '1));
		send_sample(make_sample({3{16'h7FFF}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h7FFF}}, '1));
		// diagonal just under one
		send_sample(make_sample(pack_vec(11585, 11585, 0), pack_vec(11585, 11585, 0),
			pack_vec(0, 11585, -11585), pack_vec(0, 11585, -11585), '1));
		send_sample(make_sample(pack_vec(Q_ONE, 0, 0), pack_vec(Q_ONE, 0, 0),
			pack_vec(Q_ONE, 0, 0), pack_vec(Q_ONE, 0, 0), '0));
		send_sample(make_sample(pack_vec(Q_ONE, 0, 0), pack_vec(9000, 3000, 0),
			pack_vec(Q_ONE, 0, 0), pack_vec(15000, 200, 0), 24'h010203));
		// zero exponent: power is one even for a zero dot
		settle();
		write_reg(phong_pkg::REG_SHININESS, 24'd0);
		send_sample(make_sample(pack_vec(0, Q_ONE, 0), pack_vec(0, Q_ONE, 0), '0,
			pack_vec(0, Q_ONE, 0), '1));
		send_sample(make_sample(pack_vec(0, Q_ONE, 0), pack_vec(0, Q_ONE, 0),
			pack_vec(0, 0, Q_ONE), pack_vec(0, 0, -Q_ONE), '1));
		send_sample(make_sample(pack_vec(0, Q_ONE, 0), pack_vec(0, Q_ONE, 0),
			pack_vec(Q_ONE, 0, 0), pack_vec(Q_ONE, 0, 0), 24'hA5C35A));
	endtask

	task automatic test_register_writes();
		settle();
		// upper data bits beyond the exponent width are dropped
		write_reg(phong_pkg::REG_SHININESS, 24'hABCDFF);
		send_sample(make_sample(pack_vec(Q_ONE, 0, 0), pack_vec(Q_ONE, 0, 0),
			pack_vec(Q_ONE, 0, 0), pack_vec(Q_ONE, 0, 0), '1));
		send_sample(make_sample(pack_vec(Q_ONE, 0, 0), pack_vec(Q_ONE, 0, 0),
			pack_vec(Q_ONE, 40, 0), pack_vec(Q_ONE - 30, 0, 20), '1));
		settle();
		// a write to an unused index must leave the material alone
		write_reg(REG_UNMAPPED, '0);
		send_sample(make_sample(pack_vec(0, 0, Q_ONE), pack_vec(0, 0, Q_ONE),
			pack_vec(0, 0, Q_ONE), pack_vec(0, 10, Q_ONE - 10), '1));
		settle();
		write_reg(phong_pkg::REG_DIFFUSE_COLOR, '0);
		write_reg(phong_pkg::REG_SPECULAR_COLOR, '0);
		send_sample(make_sample(pack_vec(Q_ONE, 0, 0), pack_vec(Q_ONE, 0, 0),
			pack_vec(Q_ONE, 0, 0), pack_vec(Q_ONE, 0, 0), '1));
		settle();
		write_reg(phong_pkg::REG_DIFFUSE_COLOR, 24'h00FF00);
		write_reg(phong_pkg::REG_SPECULAR_COLOR, 24'h0000FF);
		send_sample(make_sample(pack_vec(0, Q_ONE, 0), pack_vec(0, 12000, 0),
			pack_vec(0, Q_ONE, 0), pack_vec(0, Q_ONE, 100), '1));
	endtask

	task automatic test_random_shading();
		int p;
		int n;
		for (p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			if (p == 0) begin
				write_reg(phong_pkg::REG_DIFFUSE_COLOR, '1);
				write_reg(phong_pkg::REG_SPECULAR_COLOR, '1);
				write_reg(phong_pkg::REG_SHININESS, 24'd255);
			end else if (p == 1) begin
				write_reg(phong_pkg::REG_DIFFUSE_COLOR, '0);
				write_reg(phong_pkg::REG_SPECULAR_COLOR, '0);
				write_reg(phong_pkg::REG_SHININESS, 24'd0);
			end else begin
				write_reg(phong_pkg::REG_DIFFUSE_COLOR, rgb_t'($urandom));
				write_reg(phong_pkg::REG_SPECULAR_COLOR, rgb_t'($urandom));
				write_reg(phong_pkg::REG_SHININESS, ($urandom_range(0, 1) == 1)
					? rgb_t'($urandom_range(0, 16)) : rgb_t'($urandom));
			end
			for (n = 0; n < PHASE_SAMPLES; n++)
				send_sample(rand_sample());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid        = 1'b0;
		req.incoming_dir = '0;
		req.normal_dir   = '0;
		req.reflect_dir  = '0;
		req.view_dir     = '0;
		req.light_color  = '0;
		cfg.valid = 1'b0;
		cfg.index = phong_pkg::REG_DIFFUSE_COLOR;
		cfg.data  = '0;
		diffuse_reg  = rgb_t'(CMAX) << (2*COLOR_BITS);
		specular_reg = '0;
		shine_reg    = exp_t'(2);
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_config();
		test_edge_cases();
		test_register_writes();
		test_random_shading();
		settle();

		if (expected_shades.size() != 0)
			log_error($sformatf("%0d shaded words never arrived", expected_shades.size()));
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: phong_light_shading_core.f
rtl/core/phong_pkg.sv
rtl/core/phong_if.sv
rtl/core/phong_light_shading_core.sv
tb/phong_light_shading_core_tb.sv
